FILE: src/tdpt_pkg.sv
// package with constants, types and state codes for the trial division prime test core
`default_nettype none
package tdpt_pkg;

    // width of the tested number
    localparam int NUM_WIDTH = 16;
    // number of divisor cells in the chain
    localparam int NUM_CELLS = 64;
    localparam int IDX_W     = $clog2(NUM_CELLS);
    // divisor width: square root range plus one round of cells plus headroom
    localparam int DIV_W     = (NUM_WIDTH + 1) / 2 + IDX_W + 1;
    localparam int SQ_W      = 2 * DIV_W;
    // end value of the round counter in the run state
    localparam int ROUND_CYC = NUM_WIDTH + NUM_CELLS;
    localparam int CNT_W     = $clog2(ROUND_CYC);
    localparam int BIT_W     = $clog2(NUM_WIDTH);
    // stream widths in whole bytes
    localparam int IN_TW     = ((NUM_WIDTH + 7) / 8) * 8;
    localparam int OUT_TW    = ((NUM_WIDTH + 1 + 7) / 8) * 8;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_LOAD,
        ST_RUN,
        ST_FIN
    } tdpt_state_t;

    // broadcast control from the sequencer to every cell
    typedef struct packed {
        logic                 load;
        logic [DIV_W-1:0]     base;
        logic [NUM_WIDTH-1:0] num;
    } cell_ctl_t;

endpackage
`default_nettype wire

FILE: src/tdpt_cell.sv
// one divisor cell: bit-serial remainder of the number by its own divisor
`default_nettype none
module tdpt_cell
    import tdpt_pkg::*;
(
    input  wire logic             aclk,
    input  wire logic             aresetn,
    input  wire cell_ctl_t        ctl,
    input  wire logic [IDX_W-1:0] idx,
    input  wire logic             in_bit,
    input  wire logic             in_vld,
    output logic                  out_bit,
    output logic                  out_vld,
    output logic                  hit
);

    logic [DIV_W-1:0] d_reg;
    logic [DIV_W-1:0] r_reg;
    logic [DIV_W-1:0] r_next;
    logic [SQ_W-1:0]  sq_reg;
    logic             bit_reg;
    logic             vld_reg;
    logic [DIV_W:0]   shifted;

    // shift in one bit and reduce once
    always_comb begin
        shifted = {r_reg, in_bit};
        if (shifted >= {1'b0, d_reg}) begin
            shifted = shifted - {1'b0, d_reg};
        end
        r_next = shifted[DIV_W-1:0];
    end

    // divisor, remainder and square
    always_ff @(posedge aclk) begin
        if (ctl.load) begin
            d_reg <= ctl.base + DIV_W'(idx);
            r_reg <= '0;
        end else if (in_vld) begin
            r_reg <= r_next;
        end
        sq_reg  <= d_reg * d_reg;
        bit_reg <= in_bit;
    end

    // valid flag travels with the bit to the neighbor
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= 1'b0;
        end else begin
            vld_reg <= in_vld && !ctl.load;
        end
    end

    assign out_bit = bit_reg;
    assign out_vld = vld_reg;
    // divides evenly and lies within the square root bound
    assign hit = (r_reg == '0) && (sq_reg <= SQ_W'(ctl.num));

endmodule
`default_nettype wire

FILE: src/trial_division_prime_test_core.sv
// top level of the trial division prime test core: sequencer and cell chain
// One item in, one item out. A chain of 64 divisor cells tests divisors base to base+63
// in one round; the number's bits stream MSB first down the chain, and each round is a
// load state followed by a run state. Rounds repeat until a divisor divides the number
// or the next base squared exceeds it: at most 4 rounds for a 16-bit number; 0 and 1
// skip the rounds. A new item is taken once the previous result has moved into the
// output register, while that result may still wait there.
`default_nettype none
module trial_division_prime_test_core
    import tdpt_pkg::*;
(
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire logic              s_tvalid,
    output logic                   s_tready,
    input  wire logic [IN_TW-1:0]  s_tdata,   // candidate
    output logic                   m_tvalid,
    input  wire logic              m_tready,
    output logic [OUT_TW-1:0]      m_tdata    // tested_value, prime_flag
);

    tdpt_state_t          state_reg, state_next;
    logic [NUM_WIDTH-1:0] num_reg;
    logic [DIV_W-1:0]     base_reg;
    logic [DIV_W-1:0]     nbase;
    logic [SQ_W-1:0]      lim_sq_reg;
    logic [CNT_W-1:0]     cnt_reg;
    logic                 flag_reg;
    logic                 out_vld_reg;
    logic                 out_flag_reg;
    logic [NUM_WIDTH-1:0] out_val_reg;
    cell_ctl_t            ctl;
    logic [NUM_CELLS:0]   chain_bit;
    logic [NUM_CELLS:0]   chain_vld;
    logic [NUM_CELLS-1:0] hits;
    logic                 any_hit;
    logic                 round_end;
    logic                 last_round;
    logic                 in_acc;
    logic                 out_free;
    logic [BIT_W-1:0]     bit_idx;

    assign in_acc     = s_tvalid && s_tready;
    assign out_free   = !out_vld_reg || m_tready;
    assign nbase      = base_reg + DIV_W'(NUM_CELLS);
    assign any_hit    = |hits;
    assign round_end  = (state_reg == ST_RUN) && (cnt_reg == CNT_W'(ROUND_CYC));
    assign last_round = lim_sq_reg > SQ_W'(num_reg);

    // next state
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE: begin
                if (in_acc) begin
                    state_next = (s_tdata[NUM_WIDTH-1:1] == '0) ? ST_FIN : ST_LOAD;
                end
            end
            ST_LOAD: state_next = ST_RUN;
            ST_RUN: begin
                if (round_end) begin
                    state_next = (any_hit || last_round) ? ST_FIN : ST_LOAD;
                end
            end
            ST_FIN: begin
                if (out_free) begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    // outputs of the sequencer
    always_comb begin
        s_tready  = (state_reg == ST_IDLE);
        ctl.load  = (state_reg == ST_LOAD);
        ctl.base  = base_reg;
        ctl.num   = num_reg;
        bit_idx   = BIT_W'(NUM_WIDTH - 1) - cnt_reg[BIT_W-1:0];
    end

    // head of the chain: number bits MSB first
    assign chain_bit[0] = num_reg[bit_idx];
    assign chain_vld[0] = (state_reg == ST_RUN) && (cnt_reg < CNT_W'(NUM_WIDTH));

    // control registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            out_vld_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            if (state_reg == ST_FIN && out_free) begin
                out_vld_reg <= 1'b1;
            end else if (m_tready) begin
                out_vld_reg <= 1'b0;
            end
        end
    end

    // datapath registers
    always_ff @(posedge aclk) begin
        lim_sq_reg <= nbase * nbase;
        if (in_acc) begin
            num_reg  <= s_tdata[NUM_WIDTH-1:0];
            base_reg <= DIV_W'(2);
            flag_reg <= 1'b0;
        end
        if (state_reg == ST_LOAD) begin
            cnt_reg <= '0;
        end else if (state_reg == ST_RUN) begin
            cnt_reg <= cnt_reg + 1'b1;
        end
        if (round_end) begin
            flag_reg <= !any_hit;
            base_reg <= nbase;
        end
        if (state_reg == ST_FIN && out_free) begin
            out_flag_reg <= flag_reg;
            out_val_reg  <= num_reg;
        end
    end

    // chain of divisor cells
    for (genvar i = 0; i < NUM_CELLS; i++) begin : g_cell
        tdpt_cell u_cell (
            .aclk    (aclk),
            .aresetn (aresetn),
            .ctl     (ctl),
            .idx     (IDX_W'(i)),
            .in_bit  (chain_bit[i]),
            .in_vld  (chain_vld[i]),
            .out_bit (chain_bit[i+1]),
            .out_vld (chain_vld[i+1]),
            .hit     (hits[i])
        );
    end

    assign m_tvalid = out_vld_reg;
    assign m_tdata  = OUT_TW'({out_val_reg, out_flag_reg});

endmodule
`default_nettype wire
